### sv/pba_pkg.sv
package pba_pkg;

    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int PAGE_INDEX_W = 12;
    localparam int PAGE_COUNT_W = 13;
    localparam int TOTAL_W      = 13;
    localparam int USED_W       = 13;

    localparam logic [TOTAL_W-1:0] TOTAL_PAGES_RESET = 13'd4096;

    typedef logic [CMD_W-1:0]        cmd_t;
    typedef logic [STATUS_W-1:0]     status_t;
    typedef logic [PAGE_INDEX_W-1:0] page_index_t;
    typedef logic [PAGE_COUNT_W-1:0] page_count_t;
    typedef logic [USED_W-1:0]       used_count_t;

    localparam cmd_t CMD_ALLOC   = 2'd0;
    localparam cmd_t CMD_FREE    = 2'd1;
    localparam cmd_t CMD_RESERVE = 2'd2;
    localparam cmd_t CMD_TEST    = 2'd3;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_NO_MEM = 2'd1;
    localparam status_t STATUS_ZERO   = 2'd2;

endpackage

### sv/pba_bitmap_ram.sv
module pba_bitmap_ram #(
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/page_bitmap_allocator_core.sv
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  command, page_index, page_count
// rsp       out        rsp_valid / rsp_ready  status, alloc_page, run_busy, used_count
// cfg       in         cfg_valid / cfg_ready  cfg_data (total_pages)
//
// one request at a time through a single bitmap ram with a registered read port,
// one page per cycle: alloc first scans for the first fitting run, then marks it
// in a run walk; free, reserve and test walk the run clipped at the bitmap end,
// test stopping early at the first used page.
// after reset a clearing pass over all NUM_PAGES pages zeroes the bitmap, req_ready low.
// a finished response waits in the output register while the next request is taken.
module page_bitmap_allocator_core #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  pba_pkg::cmd_t        command,
    input  pba_pkg::page_index_t page_index,
    input  pba_pkg::page_count_t page_count,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output pba_pkg::status_t     status,
    output pba_pkg::page_index_t alloc_page,
    output logic                 run_busy,
    output pba_pkg::used_count_t used_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [12:0]          cfg_data
);
    import pba_pkg::*;

    localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(NUM_PAGES + 1);
    localparam int PW = (CW > PAGE_COUNT_W) ? CW : PAGE_COUNT_W;
    localparam logic [PW-1:0] NUM_PAGES_P = PW'(NUM_PAGES);
    localparam logic [PW-1:0] LAST_PAGE_P = PW'(NUM_PAGES - 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    page_count_t       count_reg, count_next;
    logic [PW-1:0]     iss_ptr_reg, iss_ptr_next;
    page_count_t       iss_left_reg, iss_left_next;
    logic [PW-1:0]     chk_ptr_reg, chk_ptr_next;
    logic              pend_reg, pend_next;
    page_count_t       run_len_reg, run_len_next;
    logic [PW-1:0]     limit_reg, limit_next;
    logic [PW-1:0]     page_reg, page_next;
    status_t           status_reg, status_next;
    logic              busy_reg, busy_next;
    logic [PW-1:0]     used_reg, used_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic              rsp_valid_reg, rsp_valid_next;
    status_t           rsp_status_reg, rsp_status_next;
    page_index_t       rsp_page_reg, rsp_page_next;
    logic              rsp_busy_reg, rsp_busy_next;
    used_count_t       rsp_used_reg, rsp_used_next;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic              mem_wd;
    logic              rd_bit;
    logic              can_scan;
    logic              can_run;
    logic              scan_hit;
    logic [PW-1:0]     alloc_limit;
    page_count_t       run_len_inc;

    pba_bitmap_ram #(
        .DEPTH(NUM_PAGES)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (iss_ptr_reg[AW-1:0]),
        .rd_data (rd_bit)
    );

    assign req_ready  = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign alloc_page = rsp_page_reg;
    assign run_busy   = rsp_busy_reg;
    assign used_count = rsp_used_reg;

    assign can_scan    = (iss_ptr_reg < limit_reg);
    assign can_run     = (iss_left_reg != '0) && (iss_ptr_reg < NUM_PAGES_P);
    assign run_len_inc = run_len_reg + 1'b1;
    assign scan_hit    = pend_reg && !rd_bit && (run_len_inc == count_reg);
    assign alloc_limit = (PW'(total_reg) < NUM_PAGES_P) ? PW'(total_reg) : NUM_PAGES_P;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        iss_ptr_next    = iss_ptr_reg;
        iss_left_next   = iss_left_reg;
        chk_ptr_next    = chk_ptr_reg;
        pend_next       = pend_reg;
        run_len_next    = run_len_reg;
        limit_next      = limit_reg;
        page_next       = page_reg;
        status_next     = status_reg;
        busy_next       = busy_reg;
        used_next       = used_reg;
        total_next      = total_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_page_next   = rsp_page_reg;
        rsp_busy_next   = rsp_busy_reg;
        rsp_used_next   = rsp_used_reg;
        mem_we          = 1'b0;
        mem_wa          = chk_ptr_reg[AW-1:0];
        mem_wd          = 1'b0;

        if (cfg_valid)
        begin
            total_next = cfg_data;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = iss_ptr_reg[AW-1:0];
                if (iss_ptr_reg == LAST_PAGE_P)
                begin
                    iss_ptr_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    iss_ptr_next = iss_ptr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next      = command;
                    count_next    = page_count;
                    status_next   = STATUS_OK;
                    busy_next     = 1'b0;
                    page_next     = '0;
                    pend_next     = 1'b0;
                    run_len_next  = '0;
                    limit_next    = alloc_limit;
                    iss_left_next = page_count;
                    if (page_count == '0)
                    begin
                        status_next = STATUS_ZERO;
                        state_next  = ST_FIN;
                    end
                    else if (command == CMD_ALLOC)
                    begin
                        iss_ptr_next = '0;
                        // a run longer than the allocatable range can never fit
                        if (PW'(page_count) > alloc_limit)
                        begin
                            status_next = STATUS_NO_MEM;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        iss_ptr_next = PW'(page_index);
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next    = can_scan;
                chk_ptr_next = iss_ptr_reg;
                if (can_scan)
                begin
                    iss_ptr_next = iss_ptr_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    run_len_next = rd_bit ? '0 : run_len_inc;
                end
                if (scan_hit)
                begin
                    // run is known free: mark it through the reserve walk
                    page_next     = chk_ptr_reg + PW'(1) - PW'(count_reg);
                    iss_ptr_next  = chk_ptr_reg + PW'(1) - PW'(count_reg);
                    iss_left_next = count_reg;
                    pend_next     = 1'b0;
                    state_next    = ST_RUN;
                end
                else if (!pend_reg && !can_scan)
                begin
                    status_next = STATUS_NO_MEM;
                    state_next  = ST_FIN;
                end
            end
            ST_RUN:
            begin
                pend_next    = can_run;
                chk_ptr_next = iss_ptr_reg;
                if (can_run)
                begin
                    iss_ptr_next  = iss_ptr_reg + 1'b1;
                    iss_left_next = iss_left_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    case (cmd_reg) inside
                        CMD_TEST:
                        begin
                            if (rd_bit)
                            begin
                                busy_next  = 1'b1;
                                pend_next  = 1'b0;
                                state_next = ST_FIN;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (rd_bit)
                            begin
                                mem_we    = 1'b1;
                                mem_wd    = 1'b0;
                                used_next = used_reg - 1'b1;
                            end
                        end
                        CMD_ALLOC, CMD_RESERVE:
                        begin
                            if (!rd_bit)
                            begin
                                mem_we    = 1'b1;
                                mem_wd    = 1'b1;
                                used_next = used_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (!pend_reg && !can_run)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_page_next   = page_reg[PAGE_INDEX_W-1:0];
                    rsp_busy_next   = busy_reg;
                    rsp_used_next   = used_reg[USED_W-1:0];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cmd_reg        <= CMD_ALLOC;
            count_reg      <= '0;
            iss_ptr_reg    <= '0;
            iss_left_reg   <= '0;
            chk_ptr_reg    <= '0;
            pend_reg       <= 1'b0;
            run_len_reg    <= '0;
            limit_reg      <= '0;
            page_reg       <= '0;
            status_reg     <= STATUS_OK;
            busy_reg       <= 1'b0;
            used_reg       <= '0;
            total_reg      <= TOTAL_PAGES_RESET;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= STATUS_OK;
            rsp_page_reg   <= '0;
            rsp_busy_reg   <= 1'b0;
            rsp_used_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            count_reg      <= count_next;
            iss_ptr_reg    <= iss_ptr_next;
            iss_left_reg   <= iss_left_next;
            chk_ptr_reg    <= chk_ptr_next;
            pend_reg       <= pend_next;
            run_len_reg    <= run_len_next;
            limit_reg      <= limit_next;
            page_reg       <= page_next;
            status_reg     <= status_next;
            busy_reg       <= busy_next;
            used_reg       <= used_next;
            total_reg      <= total_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_page_reg   <= rsp_page_next;
            rsp_busy_reg   <= rsp_busy_next;
            rsp_used_reg   <= rsp_used_next;
        end
    end

`ifndef ASSERT_OFF
    // the used counter can never pass the bitmap size
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NUM_PAGES_P)
        else $error("used page count above bitmap size");

    // a read in flight exists only while walking the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN || state_reg == ST_RUN))
        else $error("bitmap read pending outside a walk");

    // run writes stay inside the bitmap
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == ST_RUN) |-> (chk_ptr_reg < NUM_PAGES_P))
        else $error("bitmap write beyond last page");

    // a scan only starts for a run that can fit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (PW'(count_reg) <= limit_reg && count_reg != '0))
        else $error("scan running for a run that cannot fit");

    // zero count responses carry no page and no busy flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == STATUS_ZERO) |-> (alloc_page == '0 && !run_busy))
        else $error("zero count response with payload");
`endif

endmodule
